/* rtl/core/dpbs_pkg.sv */
// Shared types, constants and codes of the device poll backoff scheduler.
package dpbs_pkg;

  localparam int unsigned DEVICES        = 16;
  localparam int unsigned DEV_W          = $clog2(DEVICES);
  localparam logic [31:0] POLL_WINDOW_MS = 32'd60000;
  localparam int unsigned NUM_REGS       = 8;
  localparam int unsigned REG_W          = 24;
  localparam int unsigned REG_IDX_W      = 3;
  localparam int unsigned S_TDATA_W      = 72;
  localparam int unsigned M_TDATA_W      = 112;
  localparam logic [7:0]  STREAK_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    OP_BEGIN         = 3'd0,
    OP_CLEAR         = 3'd1,
    OP_SET_NEXT      = 3'd2,
    OP_FAILURE       = 3'd3,
    OP_CLEAR_STREAKS = 3'd4,
    OP_POP_DUE       = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CFG_AUTH_FIRST    = 3'd0,
    CFG_AUTH_SECOND   = 3'd1,
    CFG_AUTH_MAX      = 3'd2,
    CFG_STATUS_FIRST  = 3'd3,
    CFG_STATUS_SECOND = 3'd4,
    CFG_STATUS_THIRD  = 3'd5,
    CFG_STATUS_FOURTH = 3'd6,
    CFG_STATUS_MAX    = 3'd7
  } cfg_idx_e;

  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    24'd5000, 24'd15000, 24'd60000, 24'd1000, 24'd2000, 24'd4000, 24'd8000, 24'd15000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_STEP,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
    logic calc;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_pop;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/dpbs_ctrl.sv */
// Controller state machine that sequences accept, scan, slot load, step and commit.
module dpbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  dpbs_pkg::dp_status_t  status_i,
  output logic                  s_tready_o,
  output dpbs_pkg::dp_cmd_t     cmd_o
);

  dpbs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpbs_pkg::ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = status_i.in_pop ? dpbs_pkg::ST_SCAN : dpbs_pkg::ST_LOAD;
        end
      end
      dpbs_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = dpbs_pkg::ST_LOAD;
        end
      end
      dpbs_pkg::ST_LOAD: state_d = dpbs_pkg::ST_STEP;
      dpbs_pkg::ST_STEP: state_d = dpbs_pkg::ST_COMMIT;
      dpbs_pkg::ST_COMMIT: begin
        if (status_i.out_free) begin
          state_d = dpbs_pkg::ST_IDLE;
        end
      end
      default: state_d = dpbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      dpbs_pkg::ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
      end
      dpbs_pkg::ST_SCAN:   cmd_o.scan   = 1'b1;
      dpbs_pkg::ST_LOAD:   cmd_o.load   = 1'b1;
      dpbs_pkg::ST_STEP:   cmd_o.calc   = 1'b1;
      dpbs_pkg::ST_COMMIT: cmd_o.commit = status_i.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/dpbs_datapath.sv */
// Datapath: slot table, backoff registers, item capture, scan, step logic and result register.
module dpbs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [dpbs_pkg::S_TDATA_W-1:0]       s_tdata_i,
  input  dpbs_pkg::dp_cmd_t                    cmd_i,
  output dpbs_pkg::dp_status_t                 status_o,
  input  logic                                 cfg_we_i,
  input  logic [dpbs_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [dpbs_pkg::REG_W-1:0]           cfg_wdata_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [dpbs_pkg::M_TDATA_W-1:0]       m_tdata_o
);

  localparam int unsigned DW = dpbs_pkg::DEV_W;

  // Backoff registers.
  logic [dpbs_pkg::REG_W-1:0] cfg_q [dpbs_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpbs_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= dpbs_pkg::CFG_RESET[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // Captured item.
  logic [2:0]    op_q;
  logic [DW-1:0] dev_q;
  logic [31:0]   now_q;
  logic [31:0]   tv_q;
  logic          auth_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= s_tdata_i[2:0];
      dev_q  <= s_tdata_i[6:3];
      now_q  <= s_tdata_i[38:7];
      tv_q   <= s_tdata_i[70:39];
      auth_q <= s_tdata_i[71];
    end
  end

  // Slot table.
  logic          valid_q [dpbs_pkg::DEVICES];
  logic [31:0]   npt_q   [dpbs_pkg::DEVICES];
  logic [31:0]   dl_q    [dpbs_pkg::DEVICES];
  logic [7:0]    ss_q    [dpbs_pkg::DEVICES];
  logic [7:0]    as_q    [dpbs_pkg::DEVICES];

  logic          wr_en;
  logic [DW-1:0] wr_idx;
  logic          wr_valid;
  logic [31:0]   wr_npt, wr_dl;
  logic [7:0]    wr_ss, wr_as;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpbs_pkg::DEVICES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      valid_q[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      npt_q[wr_idx] <= wr_npt;
      dl_q[wr_idx]  <= wr_dl;
      ss_q[wr_idx]  <= wr_ss;
      as_q[wr_idx]  <= wr_as;
    end
  end

  // Scan pointer and read port. A slot that was never created reads as zero.
  logic [DW-1:0] scan_idx_q;
  logic          found_q;
  logic [DW-1:0] rd_idx;
  logic          r_valid;
  logic [31:0]   r_npt, r_dl;
  logic [7:0]    r_ss, r_as;
  logic          is_pop;

  assign is_pop  = (op_q == dpbs_pkg::OP_POP_DUE);
  assign rd_idx  = (cmd_i.scan || is_pop) ? scan_idx_q : dev_q;
  assign r_valid = valid_q[rd_idx];
  assign r_npt   = npt_q[rd_idx] & {32{r_valid}};
  assign r_dl    = dl_q[rd_idx] & {32{r_valid}};
  assign r_ss    = ss_q[rd_idx] & {8{r_valid}};
  assign r_as    = as_q[rd_idx] & {8{r_valid}};

  logic scan_due, scan_live, scan_hit, scan_last;

  assign scan_due  = r_valid && (r_npt != '0) && (now_q > r_npt);
  assign scan_live = (r_dl != '0) && (now_q <= r_dl);
  assign scan_hit  = scan_due && scan_live;
  assign scan_last = (scan_idx_q == DW'(dpbs_pkg::DEVICES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.accept) begin
      scan_idx_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      found_q <= scan_hit;
      if (!scan_hit && !scan_last) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
  end

  // Loaded slot.
  logic        s_valid;
  logic [31:0] s_npt, s_dl;
  logic [7:0]  s_ss, s_as;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_valid <= r_valid;
      s_npt   <= r_npt;
      s_dl    <= r_dl;
      s_ss    <= r_ss;
      s_as    <= r_as;
    end
  end

  // Failure step: new streaks and the stepped backoff.
  logic [7:0]                 ss_c_q, as_c_q, ss_inc, as_inc;
  logic [dpbs_pkg::REG_W-1:0] b_q, b_d;

  assign ss_inc = (s_ss == dpbs_pkg::STREAK_MAX) ? s_ss : s_ss + 8'd1;
  assign as_inc = (s_as == dpbs_pkg::STREAK_MAX) ? s_as : s_as + 8'd1;

  always_comb begin
    if (auth_q) begin
      if (as_inc <= 8'd1)      b_d = cfg_q[dpbs_pkg::CFG_AUTH_FIRST];
      else if (as_inc == 8'd2) b_d = cfg_q[dpbs_pkg::CFG_AUTH_SECOND];
      else                     b_d = cfg_q[dpbs_pkg::CFG_AUTH_MAX];
    end else begin
      if (ss_inc <= 8'd1)      b_d = cfg_q[dpbs_pkg::CFG_STATUS_FIRST];
      else if (ss_inc == 8'd2) b_d = cfg_q[dpbs_pkg::CFG_STATUS_SECOND];
      else if (ss_inc == 8'd3) b_d = cfg_q[dpbs_pkg::CFG_STATUS_THIRD];
      else if (ss_inc == 8'd4) b_d = cfg_q[dpbs_pkg::CFG_STATUS_FOURTH];
      else                     b_d = cfg_q[dpbs_pkg::CFG_STATUS_MAX];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      b_q    <= b_d;
      ss_c_q <= auth_q ? 8'd0 : ss_inc;
      as_c_q <= auth_q ? as_inc : 8'd0;
    end
  end

  // Commit: new slot contents for the addressed operation.
  logic [31:0]                sum_b, begin_dl, begin_npt;
  logic                       s_active;
  logic                       n_valid;
  logic [31:0]                n_npt, n_dl;
  logic [7:0]                 n_ss, n_as;
  logic [dpbs_pkg::REG_W-1:0] n_backoff;

  assign sum_b     = now_q + {8'd0, b_q};
  assign begin_dl  = now_q + dpbs_pkg::POLL_WINDOW_MS;
  assign begin_npt = (tv_q == '0) ? '0 : now_q + tv_q;
  assign s_active  = (s_dl != '0) && (now_q <= s_dl);

  always_comb begin
    n_valid   = s_valid;
    n_npt     = s_npt;
    n_dl      = s_dl;
    n_ss      = s_ss;
    n_as      = s_as;
    n_backoff = '0;
    case (op_q)
      dpbs_pkg::OP_BEGIN: begin
        n_valid = 1'b1;
        n_dl    = begin_dl;
        n_npt   = begin_npt;
        n_ss    = '0;
        n_as    = '0;
      end
      dpbs_pkg::OP_CLEAR: begin
        if (s_valid) begin
          n_npt = '0;
          n_dl  = '0;
          n_ss  = '0;
          n_as  = '0;
        end
      end
      dpbs_pkg::OP_SET_NEXT: begin
        n_valid = 1'b1;
        n_npt   = tv_q;
      end
      dpbs_pkg::OP_FAILURE: begin
        if (s_valid) begin
          if (s_active && (sum_b <= s_dl)) begin
            n_npt     = sum_b;
            n_ss      = ss_c_q;
            n_as      = as_c_q;
            n_backoff = b_q;
          end else begin
            n_npt = '0;
            n_dl  = '0;
            n_ss  = '0;
            n_as  = '0;
          end
        end
      end
      dpbs_pkg::OP_CLEAR_STREAKS: begin
        if (s_valid) begin
          n_ss = '0;
          n_as = '0;
        end
      end
      default: ;
    endcase
  end

  // Table write port: scan wipes or disarms, commit stores the step.
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = dev_q;
    wr_valid = n_valid;
    wr_npt   = n_npt;
    wr_dl    = n_dl;
    wr_ss    = n_ss;
    wr_as    = n_as;
    if (cmd_i.scan) begin
      wr_en    = scan_due;
      wr_idx   = scan_idx_q;
      wr_valid = 1'b1;
      wr_npt   = '0;
      wr_dl    = scan_live ? r_dl : '0;
      wr_ss    = scan_live ? r_ss : '0;
      wr_as    = scan_live ? r_as : '0;
    end else if (cmd_i.commit && !is_pop) begin
      wr_en = 1'b1;
    end
  end

  // Result register.
  logic                           out_valid_q;
  logic [dpbs_pkg::M_TDATA_W-1:0] out_data_q;
  logic                           show;
  logic                           n_active;
  logic [DW-1:0]                  res_dev;

  assign show     = !is_pop || found_q;
  assign n_active = (n_dl != '0) && (now_q <= n_dl);
  assign res_dev  = is_pop ? (found_q ? scan_idx_q : '0) : dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {1'b0,
                     n_as & {8{show}},
                     n_ss & {8{show}},
                     n_dl & {32{show}},
                     n_npt & {32{show}},
                     n_active && show,
                     n_valid && show,
                     res_dev,
                     is_pop && found_q,
                     n_backoff};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  assign status_o.in_pop    = (s_tdata_i[2:0] == dpbs_pkg::OP_POP_DUE);
  assign status_o.scan_done = scan_hit || scan_last;
  assign status_o.out_free  = !out_valid_q || m_tready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten while still held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> is_pop)
    else $error("scan step for an item that is not pop due");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && scan_hit) |=> (npt_q[$past(scan_idx_q)] == '0 && found_q))
    else $error("popped slot not disarmed");

endmodule

/* rtl/core/device_poll_backoff_scheduler.sv */
// Top level of the device poll backoff scheduler: controller, datapath and ports.
//
//   Channel   Direction  Handshake          Payload
//   s_axis    in         tvalid / tready    tdata: operation, device, now_ms, time_value, auth_fail
//   m_axis    out        tvalid / tready    tdata: backoff .. auth_failures
//   cfg       in         cfg_we_i           cfg_index_i, cfg_wdata_i
//
// A device command passes the load, step and commit states between acceptance and a presented result.
// Pop due walks the slot table one slot per cycle over its single read/write port, up to and
// including the returned slot, then passes the same load, step and commit states.
// Reset clears the known flags of the slot table and loads the backoff registers at once.
// A new item is taken while the previous result still waits in the output register;
// the commit stalls only if that result has not been taken.
module device_poll_backoff_scheduler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // operation[2:0], device[6:3], now_ms[38:7], time_value[70:39], auth_fail[71]
  input  logic [dpbs_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // backoff[23:0], due_found[24], result_device[28:25], slot_known[29],
  // tracking_active[30], next_poll_ms[62:31], deadline_ms[94:63],
  // status_failures[102:95], auth_failures[110:103], zero[111]
  output logic [dpbs_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [dpbs_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [dpbs_pkg::REG_W-1:0]           cfg_wdata_i
);

  dpbs_pkg::dp_cmd_t    cmd;
  dpbs_pkg::dp_status_t status;

  dpbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .status_i   (status),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  dpbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

/* tb/device_poll_backoff_scheduler_tb.sv */
// Self-checking testbench for the device poll backoff scheduler.
`timescale 1ns / 1ps

module device_poll_backoff_scheduler_tb;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef struct packed {
    logic        auth;
    logic [31:0] tv;
    logic [31:0] now;
    logic [3:0]  dev;
    logic [2:0]  op;
  } poll_cmd_t;

  typedef struct packed {
    logic [7:0]  auth_n;
    logic [7:0]  status_n;
    logic [31:0] deadline;
    logic [31:0] next_poll;
    logic        active;
    logic        known;
    logic [3:0]  dev;
    logic        found;
    logic [23:0] backoff;
  } poll_result_t;

  typedef logic [dpbs_pkg::NUM_REGS-1:0][dpbs_pkg::REG_W-1:0] delay_set_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic [dpbs_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [dpbs_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [dpbs_pkg::REG_IDX_W-1:0] cfg_index_i   = '0;
  logic [dpbs_pkg::REG_W-1:0]     cfg_wdata_i   = '0;

  device_poll_backoff_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predicted copy of the slot table and the backoff registers.
  logic        known_q    [dpbs_pkg::DEVICES];
  logic [31:0] next_q     [dpbs_pkg::DEVICES];
  logic [31:0] deadline_q [dpbs_pkg::DEVICES];
  logic [7:0]  status_q   [dpbs_pkg::DEVICES];
  logic [7:0]  auth_q     [dpbs_pkg::DEVICES];
  logic [23:0] delay_reg  [dpbs_pkg::NUM_REGS];

  poll_result_t expected_results [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;
  logic [31:0]  clock_ms = 32'd0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic in_window(logic [3:0] d, logic [31:0] now);
    return deadline_q[d] != 32'd0 && now <= deadline_q[d];
  endfunction

  function automatic void wipe_entry(logic [3:0] d);
    next_q[d]     = 32'd0;
    deadline_q[d] = 32'd0;
    status_q[d]   = 8'd0;
    auth_q[d]     = 8'd0;
  endfunction

  function automatic logic [23:0] backoff_for(logic [7:0] n, logic auth);
    if (auth) begin
      if (n <= 8'd1) return delay_reg[dpbs_pkg::CFG_AUTH_FIRST];
      if (n == 8'd2) return delay_reg[dpbs_pkg::CFG_AUTH_SECOND];
      return delay_reg[dpbs_pkg::CFG_AUTH_MAX];
    end
    if (n <= 8'd1) return delay_reg[dpbs_pkg::CFG_STATUS_FIRST];
    if (n == 8'd2) return delay_reg[dpbs_pkg::CFG_STATUS_SECOND];
    if (n == 8'd3) return delay_reg[dpbs_pkg::CFG_STATUS_THIRD];
    if (n == 8'd4) return delay_reg[dpbs_pkg::CFG_STATUS_FOURTH];
    return delay_reg[dpbs_pkg::CFG_STATUS_MAX];
  endfunction

  function automatic poll_result_t schedule_step(poll_cmd_t c);
    poll_result_t r;
    logic [3:0]   d;
    logic         report;
    logic         found;
    logic [23:0]  b;
    logic [31:0]  retry_at;
    r      = '0;
    d      = c.dev;
    report = 1'b1;
    found  = 1'b0;
    case (c.op)
      dpbs_pkg::OP_POP_DUE: begin
        report = 1'b0;
        d      = 4'd0;
        for (int i = 0; i < dpbs_pkg::DEVICES && !found; i++) begin
          if (known_q[i] && next_q[i] != 32'd0 && c.now > next_q[i]) begin
            if (!in_window(i[3:0], c.now)) begin
              wipe_entry(i[3:0]);
            end else begin
              next_q[i] = 32'd0;
              found     = 1'b1;
              report    = 1'b1;
              d         = i[3:0];
            end
          end
        end
      end
      dpbs_pkg::OP_BEGIN: begin
        known_q[d]    = 1'b1;
        deadline_q[d] = c.now + dpbs_pkg::POLL_WINDOW_MS;
        next_q[d]     = (c.tv == 32'd0) ? 32'd0 : c.now + c.tv;
        status_q[d]   = 8'd0;
        auth_q[d]     = 8'd0;
      end
      dpbs_pkg::OP_CLEAR: begin
        if (known_q[d]) wipe_entry(d);
      end
      dpbs_pkg::OP_SET_NEXT: begin
        known_q[d] = 1'b1;
        next_q[d]  = c.tv;
      end
      dpbs_pkg::OP_FAILURE: begin
        if (known_q[d]) begin
          if (c.auth) begin
            status_q[d] = 8'd0;
            if (auth_q[d] < dpbs_pkg::STREAK_MAX) auth_q[d] = auth_q[d] + 8'd1;
            b = backoff_for(auth_q[d], 1'b1);
          end else begin
            auth_q[d] = 8'd0;
            if (status_q[d] < dpbs_pkg::STREAK_MAX) status_q[d] = status_q[d] + 8'd1;
            b = backoff_for(status_q[d], 1'b0);
          end
          retry_at = c.now + {8'd0, b};
          if (in_window(d, c.now) && retry_at <= deadline_q[d]) begin
            next_q[d] = retry_at;
            r.backoff = b;
          end else begin
            wipe_entry(d);
          end
        end
      end
      dpbs_pkg::OP_CLEAR_STREAKS: begin
        if (known_q[d]) begin
          status_q[d] = 8'd0;
          auth_q[d]   = 8'd0;
        end
      end
      default: begin
      end
    endcase
    r.found = found;
    r.dev   = d;
    if (report) begin
      r.known     = known_q[d];
      r.active    = in_window(d, c.now);
      r.next_poll = next_q[d];
      r.deadline  = deadline_q[d];
      r.status_n  = status_q[d];
      r.auth_n    = auth_q[d];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_checker
    poll_result_t got;
    poll_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[dpbs_pkg::M_TDATA_W-2:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item arrived with no command pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("backoff", 32'(want.backoff), 32'(got.backoff));
          check_field("due_found", 32'(want.found), 32'(got.found));
          check_field("result_device", 32'(want.dev), 32'(got.dev));
          check_field("slot_known", 32'(want.known), 32'(got.known));
          check_field("tracking_active", 32'(want.active), 32'(got.active));
          check_field("next_poll_ms", want.next_poll, got.next_poll);
          check_field("deadline_ms", want.deadline, got.deadline);
          check_field("status_failures", 32'(want.status_n), 32'(got.status_n));
          check_field("auth_failures", 32'(want.auth_n), 32'(got.auth_n));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(schedule_step(s_axis_tdata));
        items_sent++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 37);
  end

  // Entered and left just after a falling edge; tvalid stays high for a following item.
  task automatic send_item(poll_cmd_t c);
    if (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    s_axis_tdata  <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [2:0] op, logic [3:0] dev, logic [31:0] now,
                          logic [31:0] tv, logic auth);
    poll_cmd_t c;
    c.op   = op;
    c.dev  = dev;
    c.now  = now;
    c.tv   = tv;
    c.auth = auth;
    send_item(c);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_delays(delay_set_t v);
    wait_idle();
    for (int i = 0; i < dpbs_pkg::NUM_REGS; i++) begin
      cfg_we_i     <= 1'b1;
      cfg_index_i  <= dpbs_pkg::cfg_idx_e'(i);
      cfg_wdata_i  <= v[i];
      delay_reg[i] = v[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_traffic(int count, int auth_pct, bit with_calm);
    poll_cmd_t   c;
    logic [71:0] raw;
    int          pick;
    for (int k = 0; k < count; k++) begin
      calm = with_calm && k >= count / 3 && k < count / 2;
      if ($urandom_range(49) == 0) begin
        clock_ms = $urandom_range(1) ? $urandom : (32'hFFFF_0000 | $urandom_range(0, 16'hFFFF));
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 2500);
      end
      c.dev  = ($urandom_range(1) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      c.now  = clock_ms;
      c.auth = ($urandom_range(99) < auth_pct);
      c.tv   = $urandom;
      pick   = $urandom_range(99);
      if (pick < 14) begin
        c.op = dpbs_pkg::OP_BEGIN;
        case ($urandom_range(4))
          0:       c.tv = 32'd0;
          1:       c.tv = $urandom;
          default: c.tv = $urandom_range(1, 20000);
        endcase
      end else if (pick < 42) begin
        c.op = dpbs_pkg::OP_FAILURE;
      end else if (pick < 66) begin
        c.op = dpbs_pkg::OP_POP_DUE;
      end else if (pick < 76) begin
        c.op = dpbs_pkg::OP_SET_NEXT;
        case ($urandom_range(9))
          0, 1:    c.tv = 32'd0;
          2, 3, 4: c.tv = $urandom;
          default: c.tv = clock_ms + $urandom_range(0, 20000);
        endcase
      end else if (pick < 84) begin
        c.op = dpbs_pkg::OP_CLEAR;
      end else if (pick < 92) begin
        c.op = dpbs_pkg::OP_CLEAR_STREAKS;
      end else if (pick < 95) begin
        c.op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
      end else begin
        raw = 72'({$urandom, $urandom, $urandom});
        c   = raw;
      end
      send_item(c);
      if ($urandom_range(199) == 0) wait_idle();
    end
    calm = 1'b0;
  endtask

  task automatic test_directed_cases();
    send_cmd(dpbs_pkg::OP_FAILURE, 4'd3, 32'd100, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_CLEAR, 4'd3, 32'd100, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_CLEAR_STREAKS, 4'd3, 32'd100, 32'd0, 1'b1);
    send_cmd(dpbs_pkg::OP_POP_DUE, 4'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_cmd(OP_UNUSED_A, 4'd9, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(OP_UNUSED_B, 4'd15, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_BEGIN, 4'd0, 32'd1000, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_BEGIN, 4'd15, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(dpbs_pkg::OP_SET_NEXT, 4'd1, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_cmd(dpbs_pkg::OP_BEGIN, 4'd2, 32'd100, 32'd50, 1'b0);
    send_cmd(dpbs_pkg::OP_POP_DUE, 4'd7, 32'd200, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_SET_NEXT, 4'd1, 32'd0, 32'd5, 1'b0);
    send_cmd(dpbs_pkg::OP_POP_DUE, 4'd0, 32'd10, 32'd0, 1'b0);
    for (int k = 0; k < 3; k++) send_cmd(dpbs_pkg::OP_FAILURE, 4'd0, 32'd2000, 32'd0, 1'b1);
    send_cmd(dpbs_pkg::OP_BEGIN, 4'd0, 32'd5000, 32'd1, 1'b0);
    for (int k = 0; k < 5; k++) send_cmd(dpbs_pkg::OP_FAILURE, 4'd0, 32'd5000, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_FAILURE, 4'd0, 32'd5000, 32'd0, 1'b1);
    send_cmd(dpbs_pkg::OP_CLEAR_STREAKS, 4'd0, 32'd5000, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_CLEAR, 4'd0, 32'd5000, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_FAILURE, 4'd0, 32'd5000, 32'd0, 1'b0);
    send_cmd(dpbs_pkg::OP_FAILURE, 4'd15, 32'hFFFF_FFF5, 32'd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_default_delays();
    run_traffic(300, 50, 1'b1);
    wait_idle();
  endtask

  task automatic test_streak_saturation();
    logic [31:0] now;
    load_delays('0);
    now = 32'h0001_0000;
    send_cmd(dpbs_pkg::OP_BEGIN, 4'd5, now, 32'd0, 1'b0);
    for (int k = 0; k < 600; k++) begin
      now = now + $urandom_range(0, 90);
      if ($urandom_range(9) == 0) begin
        send_cmd(dpbs_pkg::OP_POP_DUE, 4'($urandom_range(0, 15)), now, $urandom,
                 1'($urandom_range(1)));
      end else begin
        send_cmd(dpbs_pkg::OP_FAILURE, 4'd5, now, $urandom, k >= 300);
      end
    end
    wait_idle();
  endtask

  task automatic test_long_delays();
    load_delays('1);
    run_traffic(150, 50, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_delays();
    delay_set_t v;
    for (int i = 0; i < dpbs_pkg::NUM_REGS; i++) v[i] = 24'($urandom_range(0, 30000));
    load_delays(v);
    run_traffic(200, 20, 1'b0);
    wait_idle();
  endtask

  task automatic test_wide_delays();
    delay_set_t v;
    for (int i = 0; i < dpbs_pkg::NUM_REGS; i++) v[i] = 24'($urandom_range(0, 24'hFFFFFF));
    load_delays(v);
    run_traffic(60, 80, 1'b0);
    for (int i = 0; i < dpbs_pkg::NUM_REGS; i++) v[i] = dpbs_pkg::CFG_RESET[i];
    load_delays(v);
    run_traffic(60, 50, 1'b0);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < dpbs_pkg::DEVICES; i++) begin
      known_q[i] = 1'b0;
      wipe_entry(i[3:0]);
    end
    for (int i = 0; i < dpbs_pkg::NUM_REGS; i++) delay_reg[i] = dpbs_pkg::CFG_RESET[i];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed_cases();
    test_default_delays();
    test_streak_saturation();
    test_long_delays();
    test_random_delays();
    test_wide_delays();
    wait_idle();
    $display("Covered %0d commands and %0d results: edge cases, streak saturation,",
             items_sent, results_seen);
    $display("and default, zero, maximum and random backoff settings.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dpbs_pkg.sv
rtl/core/dpbs_ctrl.sv
rtl/core/dpbs_datapath.sv
rtl/core/device_poll_backoff_scheduler.sv
tb/device_poll_backoff_scheduler_tb.sv
